// ===== rtl/qwt_pkg.sv =====
// Shared types, constants and decode helpers for the quoted word tokenizer.
// No dependencies; imported by every module of the block except qwt_checker.
package qwt_pkg;

    typedef enum logic [7:0] {
        MODE_START   = 8'b0000_0001,
        MODE_BETWEEN = 8'b0000_0010,
        MODE_WORD    = 8'b0000_0100,
        MODE_ESC     = 8'b0000_1000,
        MODE_HEX1    = 8'b0001_0000,
        MODE_HEX2    = 8'b0010_0000,
        MODE_OCT     = 8'b0100_0000,
        MODE_DROP    = 8'b1000_0000
    } t_mode;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } t_quote;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNCLOSED = 2'd1;
    localparam logic [1:0] ERR_ESCAPE   = 2'd2;
    localparam logic [1:0] ERR_CONTROL  = 2'd3;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5c;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       word_end;
        logic       line_end;
        logic [1:0] error_code;
        logic       last_of_run;
    } t_result;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    // {valid, digit value}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] t;
        t = 8'd0;
        if ((b >= 8'h30) && (b <= 8'h39)) begin
            t = b - 8'h30;
            return {1'b1, t[3:0]};
        end else if ((b >= 8'h61) && (b <= 8'h66)) begin
            t = b - 8'h57;
            return {1'b1, t[3:0]};
        end else if ((b >= 8'h41) && (b <= 8'h46)) begin
            t = b - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic t_result mk_result(input logic [7:0] b, input logic bv,
                                          input logic we, input logic le,
                                          input logic [1:0] err);
        t_result r;
        r.out_byte    = bv ? b : 8'd0;
        r.byte_valid  = bv;
        r.word_end    = we;
        r.line_end    = le;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/qwt_step.sv =====
// Parser state registers and the single-pass next-state / result logic.
// Depends on qwt_pkg; yields up to two results per request.
module qwt_step (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_end_of_line,
    output qwt_pkg::t_result [1:0]  o_res,
    output logic [1:0]              o_cnt
);
    import qwt_pkg::*;

    t_mode      r_mode,  n_mode;
    t_quote     r_quote, n_quote;
    logic [7:0] r_val,   n_val;
    logic [1:0] r_left,  n_left;

    t_result [1:0] res;
    logic [1:0]    cnt;
    logic          plain_go;
    t_mode         pmode;
    logic [4:0]    hx;
    logic [7:0]    b;
    logic          eol;
    logic [7:0]    v;

    always_comb begin
        b        = i_data_byte;
        eol      = i_end_of_line;
        hx       = hex_val(b);
        n_mode   = r_mode;
        n_quote  = r_quote;
        n_val    = r_val;
        n_left   = r_left;
        res      = '0;
        cnt      = 2'd0;
        plain_go = 1'b0;
        pmode    = r_mode;
        v        = b;

        unique case (r_mode)
            MODE_START, MODE_BETWEEN, MODE_WORD: begin
                plain_go = 1'b1;
            end
            MODE_ESC: begin
                if (eol) begin
                    res[0]   = mk_result(CH_BSLASH, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    cnt      = 2'd1;
                    pmode    = MODE_WORD;
                    plain_go = 1'b1;
                end else begin
                    n_mode = MODE_WORD;
                    if ((b == 8'h78) || (b == 8'h58)) begin
                        n_mode = MODE_HEX1;
                    end else if (b[7:3] == 5'b00110) begin
                        n_val  = {5'd0, b[2:0]};
                        n_left = b[2] ? 2'd1 : 2'd2;
                        n_mode = MODE_OCT;
                    end else begin
                        unique case (b)
                            8'h61:   v = 8'd7;
                            8'h62:   v = 8'd8;
                            8'h66:   v = 8'd12;
                            8'h6e:   v = 8'd10;
                            8'h72:   v = 8'd13;
                            8'h74:   v = 8'd9;
                            8'h76:   v = 8'd11;
                            default: v = b;
                        endcase
                        res[0] = mk_result(v, 1'b1, 1'b0, 1'b0, ERR_NONE);
                        cnt    = 2'd1;
                    end
                end
            end
            MODE_HEX1: begin
                if (eol || !hx[4]) begin
                    res[0]  = mk_result(8'd0, 1'b0, 1'b0, 1'b1, ERR_ESCAPE);
                    cnt     = 2'd1;
                    n_quote = QUOTE_NONE;
                    n_val   = 8'd0;
                    n_left  = 2'd0;
                    n_mode  = eol ? MODE_START : MODE_DROP;
                end else begin
                    n_val  = {4'd0, hx[3:0]};
                    n_left = 2'd1;
                    n_mode = MODE_HEX2;
                end
            end
            MODE_HEX2: begin
                n_val  = 8'd0;
                n_left = 2'd0;
                n_mode = MODE_WORD;
                if (!eol && hx[4]) begin
                    res[0] = mk_result({r_val[3:0], hx[3:0]}, 1'b1, 1'b0, 1'b0,
                                       ERR_NONE);
                    cnt    = 2'd1;
                end else begin
                    res[0]   = mk_result(r_val, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    cnt      = 2'd1;
                    pmode    = MODE_WORD;
                    plain_go = 1'b1;
                end
            end
            MODE_OCT: begin
                if (!eol && (b[7:3] == 5'b00110)) begin
                    if (r_left == 2'd1) begin
                        res[0] = mk_result({r_val[4:0], b[2:0]}, 1'b1, 1'b0, 1'b0,
                                           ERR_NONE);
                        cnt    = 2'd1;
                        n_val  = 8'd0;
                        n_left = 2'd0;
                        n_mode = MODE_WORD;
                    end else begin
                        n_val  = {r_val[4:0], b[2:0]};
                        n_left = r_left - 2'd1;
                    end
                end else begin
                    res[0]   = mk_result(r_val, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    cnt      = 2'd1;
                    n_val    = 8'd0;
                    n_left   = 2'd0;
                    n_mode   = MODE_WORD;
                    pmode    = MODE_WORD;
                    plain_go = 1'b1;
                end
            end
            MODE_DROP: begin
                if (eol) begin
                    n_mode = MODE_START;
                end
            end
            default: begin
                n_mode = MODE_START;
            end
        endcase

        if (plain_go) begin
            n_mode = pmode;
            if (eol) begin
                if (pmode == MODE_WORD) begin
                    if (r_quote != QUOTE_NONE) begin
                        res[cnt[0]] = mk_result(8'd0, 1'b0, 1'b0, 1'b1, ERR_UNCLOSED);
                    end else begin
                        res[cnt[0]] = mk_result(8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE);
                    end
                end else begin
                    res[cnt[0]] = mk_result(8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE);
                end
                cnt     = cnt + 2'd1;
                n_mode  = MODE_START;
                n_quote = QUOTE_NONE;
                n_val   = 8'd0;
                n_left  = 2'd0;
            end else if (is_blank(b)) begin
                if (r_quote != QUOTE_NONE) begin
                    res[cnt[0]] = mk_result(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    cnt         = cnt + 2'd1;
                end else if (pmode == MODE_WORD) begin
                    res[cnt[0]] = mk_result(8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
                    cnt         = cnt + 2'd1;
                    n_mode      = MODE_BETWEEN;
                end
            end else if ((b == CH_HASH) && (r_quote == QUOTE_NONE)) begin
                res[cnt[0]] = mk_result(8'd0, 1'b0, pmode != MODE_START, 1'b1,
                                        ERR_NONE);
                cnt     = cnt + 2'd1;
                n_mode  = MODE_DROP;
                n_quote = QUOTE_NONE;
                n_val   = 8'd0;
                n_left  = 2'd0;
            end else if ((b == CH_DQUOTE) || (b == CH_SQUOTE)) begin
                n_mode = MODE_WORD;
                if (r_quote == QUOTE_NONE) begin
                    n_quote = (b == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
                end else if ((r_quote == QUOTE_DOUBLE) == (b == CH_DQUOTE)) begin
                    n_quote = QUOTE_NONE;
                end else begin
                    res[cnt[0]] = mk_result(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    cnt         = cnt + 2'd1;
                end
            end else if (b == CH_BSLASH) begin
                n_mode = MODE_WORD;
                if (r_quote == QUOTE_SINGLE) begin
                    res[cnt[0]] = mk_result(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    cnt         = cnt + 2'd1;
                end else begin
                    n_mode = MODE_ESC;
                end
            end else if (b < CH_SPACE) begin
                res[cnt[0]] = mk_result(8'd0, 1'b0, 1'b0, 1'b1, ERR_CONTROL);
                cnt     = cnt + 2'd1;
                n_mode  = MODE_DROP;
                n_quote = QUOTE_NONE;
                n_val   = 8'd0;
                n_left  = 2'd0;
            end else begin
                n_mode      = MODE_WORD;
                res[cnt[0]] = mk_result(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
                cnt         = cnt + 2'd1;
            end
        end

        if (cnt == 2'd1) begin
            res[0].last_of_run = 1'b1;
        end else if (cnt == 2'd2) begin
            res[1].last_of_run = 1'b1;
        end
    end

    assign o_res = res;
    assign o_cnt = cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_START;
            r_quote <= QUOTE_NONE;
            r_val   <= 8'd0;
            r_left  <= 2'd0;
        end else if (i_en) begin
            r_mode  <= n_mode;
            r_quote <= n_quote;
            r_val   <= n_val;
            r_left  <= n_left;
        end
    end

endmodule

// ===== rtl/qwt_outbuf.sv =====
// Result register holding up to two results of one request, drained one per beat.
// Depends on qwt_pkg.
module qwt_outbuf (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  qwt_pkg::t_result [1:0]  i_res,
    input  logic [1:0]              i_cnt,
    input  logic                    i_ready,
    output logic                    o_valid,
    output qwt_pkg::t_result        o_res,
    output logic                    o_free
);
    import qwt_pkg::*;

    logic [1:0] r_cnt;
    t_result    r_res0;
    t_result    r_res1;
    logic       take;

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_res0;
    assign take    = o_valid && i_ready;
    assign o_free  = (r_cnt == 2'd0) || (take && (r_cnt == 2'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res0 <= i_res[0];
            r_res1 <= i_res[1];
        end else if (take) begin
            r_res0 <= r_res1;
        end
    end

endmodule

// ===== rtl/quoted_word_tokenizer_unit.sv =====
// Quoted word tokenizer top level: input register, parser step, result buffer.
// Throughput: 1 request per cycle when each gives at most one result and the output
// is not stalled; a request with two results holds the parser while the output
// buffer drains. Synchronous active-low reset clears parser state and all valid
// flags. Depends on qwt_pkg, qwt_step, qwt_outbuf.
module quoted_word_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_line,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_word_end,
    output logic       o_line_end,
    output logic [1:0] o_error_code,
    output logic       o_last_of_run
);
    import qwt_pkg::*;

    logic          r_in_valid;
    logic [7:0]    r_byte;
    logic          r_eol;
    logic          buf_free;
    logic          fire;
    t_result [1:0] step_res;
    logic [1:0]    step_cnt;
    t_result       out_res;

    assign fire       = r_in_valid && buf_free;
    assign o_in_ready = !r_in_valid || buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_data_byte;
            r_eol  <= i_end_of_line;
        end
    end

    qwt_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (fire),
        .i_data_byte   (r_byte),
        .i_end_of_line (r_eol),
        .o_res         (step_res),
        .o_cnt         (step_cnt)
    );

    qwt_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (step_res),
        .i_cnt   (step_cnt),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .o_free  (buf_free)
    );

    assign o_out_byte    = out_res.out_byte;
    assign o_byte_valid  = out_res.byte_valid;
    assign o_word_end    = out_res.word_end;
    assign o_line_end    = out_res.line_end;
    assign o_error_code  = out_res.error_code;
    assign o_last_of_run = out_res.last_of_run;

endmodule

// ===== rtl/qwt_checker.sv =====
// Port-level checks for quoted_word_tokenizer_unit, attached by bind.
// Depends only on the top level's ports.
module qwt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_word_end,
    input logic       o_line_end,
    input logic [1:0] o_error_code,
    input logic       o_last_of_run
);

    a_err_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_error_code != 2'd0)) |-> (o_line_end && !o_word_end
                                                     && !o_byte_valid))
        else $error("error result must end the line without closing a word");

    a_byte_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_valid) |-> (!o_word_end && !o_line_end))
        else $error("byte result carries word or line end");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_out_byte == 8'd0))
        else $error("out_byte nonzero without byte_valid");

    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_end) |-> o_last_of_run)
        else $error("line end must be the last result of its request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_byte)))
        else $error("stalled result changed");

endmodule

bind quoted_word_tokenizer_unit qwt_checker u_qwt_checker (.*);

// ===== tb/tb_quoted_word_tokenizer_unit.sv =====
// Self-checking testbench for quoted_word_tokenizer_unit: directed lines, then random lines.
// Results are checked against an in-bench word splitter, or against the typed row's own result.
// Depends on qwt_pkg and the quoted_word_tokenizer_unit RTL.
`timescale 1ns / 100ps

module tb_quoted_word_tokenizer_unit;
    import qwt_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eol;
        logic       typed;
        t_result    want;
    } t_request;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       out_ready;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_word_end;
    logic       o_line_end;
    logic [1:0] o_error_code;
    logic       o_last_of_run;
    t_request   cur_req;

    t_request   req_q[$];
    t_result    want_q[$];
    t_result    step_q[$];

    t_mode      mode;
    t_quote     quote;
    logic [7:0] esc_val;
    logic [1:0] esc_left;

    logic       calm;
    int         fail_cnt;
    int         results_seen;
    int         lines_done;
    int         words_seen;
    int         errors_seen;

    quoted_word_tokenizer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (cur_req.data),
        .i_end_of_line (cur_req.eol),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_word_end    (o_word_end),
        .o_line_end    (o_line_end),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("quoted_word_tokenizer_unit regression: fail");
        $finish;
    end

    function automatic t_request plain_row(input logic [7:0] b, input logic eol);
        t_request r;
        r.data  = b;
        r.eol   = eol;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_request typed_row(input logic [7:0] b, input logic eol,
                                           input logic [7:0] ob, input logic bv,
                                           input logic we, input logic le,
                                           input logic [1:0] err);
        t_request r;
        r.data  = b;
        r.eol   = eol;
        r.typed = 1'b1;
        r.want  = {ob, bv, we, le, err, 1'b1};
        return r;
    endfunction

    function automatic logic blank_byte(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 48;
        if (b >= 8'h61 && b <= 8'h66) return int'(b) - 97 + 10;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 65 + 10;
        return -1;
    endfunction

    task automatic emit_res(input logic [7:0] b, input logic bv, input logic we,
                            input logic le, input logic [1:0] err);
        t_result r;
        r.out_byte    = bv ? b : 8'd0;
        r.byte_valid  = bv;
        r.word_end    = we;
        r.line_end    = le;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        step_q.push_back(r);
    endtask

    task automatic clear_parse();
        mode     = MODE_START;
        quote    = QUOTE_NONE;
        esc_val  = 8'd0;
        esc_left = 2'd0;
    endtask

    task automatic raise_err(input logic [1:0] code);
        emit_res(8'd0, 1'b0, 1'b0, 1'b1, code);
        clear_parse();
        mode = MODE_DROP;
    endtask

    task automatic toggle_quote(input t_quote kind, input logic [7:0] b);
        mode = MODE_WORD;
        if (quote == QUOTE_NONE)
            quote = kind;
        else if (quote == kind)
            quote = QUOTE_NONE;
        else
            emit_res(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
    endtask

    task automatic flush_escape();
        emit_res(esc_val, 1'b1, 1'b0, 1'b0, ERR_NONE);
        esc_val  = 8'd0;
        esc_left = 2'd0;
        mode     = MODE_WORD;
    endtask

    task automatic plain_byte(input logic [7:0] b);
        if (blank_byte(b)) begin
            if (quote != QUOTE_NONE) begin
                emit_res(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
            end else if (mode == MODE_WORD) begin
                emit_res(8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
                mode = MODE_BETWEEN;
            end
        end else if (b == CH_HASH && quote == QUOTE_NONE) begin
            emit_res(8'd0, 1'b0, mode != MODE_START, 1'b1, ERR_NONE);
            clear_parse();
            mode = MODE_DROP;
        end else if (b == CH_DQUOTE) begin
            toggle_quote(QUOTE_DOUBLE, b);
        end else if (b == CH_SQUOTE) begin
            toggle_quote(QUOTE_SINGLE, b);
        end else if (b == CH_BSLASH) begin
            mode = MODE_WORD;
            if (quote == QUOTE_SINGLE)
                emit_res(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
            else
                mode = MODE_ESC;
        end else if (b < 8'd32) begin
            raise_err(ERR_CONTROL);
        end else begin
            mode = MODE_WORD;
            emit_res(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
        end
    endtask

    task automatic plain_end();
        if (mode == MODE_WORD) begin
            if (quote != QUOTE_NONE)
                emit_res(8'd0, 1'b0, 1'b0, 1'b1, ERR_UNCLOSED);
            else
                emit_res(8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE);
        end else begin
            emit_res(8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE);
        end
        clear_parse();
    endtask

    task automatic tokenize_step(input logic [7:0] b, input logic eol);
        int         d;
        logic [7:0] v;
        logic       give;
        step_q.delete();
        case (mode)
            MODE_START, MODE_BETWEEN, MODE_WORD: begin
                if (eol) plain_end();
                else plain_byte(b);
            end
            MODE_ESC: begin
                if (eol) begin
                    emit_res(CH_BSLASH, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    mode = MODE_WORD;
                    plain_end();
                end else begin
                    mode = MODE_WORD;
                    v    = b;
                    give = 1'b1;
                    case (b)
                        "x", "X": begin
                            mode = MODE_HEX1;
                            give = 1'b0;
                        end
                        "0", "1", "2", "3": begin
                            esc_val  = b - 8'h30;
                            esc_left = 2'd2;
                            mode     = MODE_OCT;
                            give     = 1'b0;
                        end
                        "4", "5", "6", "7": begin
                            esc_val  = b - 8'h30;
                            esc_left = 2'd1;
                            mode     = MODE_OCT;
                            give     = 1'b0;
                        end
                        "a": v = 8'd7;
                        "b": v = 8'd8;
                        "f": v = 8'd12;
                        "n": v = 8'd10;
                        "r": v = 8'd13;
                        "t": v = 8'd9;
                        "v": v = 8'd11;
                        default: ;
                    endcase
                    if (give) emit_res(v, 1'b1, 1'b0, 1'b0, ERR_NONE);
                end
            end
            MODE_HEX1: begin
                d = eol ? -1 : hex_nibble(b);
                if (d < 0) begin
                    raise_err(ERR_ESCAPE);
                    if (eol) clear_parse();
                end else begin
                    esc_val  = {4'd0, d[3:0]};
                    esc_left = 2'd1;
                    mode     = MODE_HEX2;
                end
            end
            MODE_HEX2: begin
                d = eol ? -1 : hex_nibble(b);
                if (d >= 0) begin
                    esc_val = {esc_val[3:0], d[3:0]};
                    flush_escape();
                end else begin
                    flush_escape();
                    if (eol) plain_end();
                    else plain_byte(b);
                end
            end
            MODE_OCT: begin
                if (!eol && b >= 8'h30 && b <= 8'h37) begin
                    esc_val  = {esc_val[4:0], b[2:0]};
                    esc_left = esc_left - 2'd1;
                    if (esc_left == 2'd0) flush_escape();
                end else begin
                    flush_escape();
                    if (eol) plain_end();
                    else plain_byte(b);
                end
            end
            default: begin
                if (eol) clear_parse();
            end
        endcase
        if (step_q.size() > 0) step_q[step_q.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        req_q.push_back(plain_row(b, 1'b0));
    endtask

    task automatic queue_line();
        int         n;
        int         kind;
        logic [7:0] q;
        string      hexset;
        string      escset;
        hexset = "0123456789abcdefABCDEF";
        escset = "abfnrtv";
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) queue_byte(CH_SPACE);
        n = $urandom_range(0, 6);
        repeat (n) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                repeat ($urandom_range(1, 4))
                    queue_byte(8'($urandom_range(8'h61, 8'h7a)));
            end else if (kind < 45) begin
                queue_byte($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
            end else if (kind < 60) begin
                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                queue_byte(q);
                repeat ($urandom_range(0, 4))
                    queue_byte(8'($urandom_range(8'h20, 8'h7e)));
                if ($urandom_range(0, 9) != 0) queue_byte(q);
            end else if (kind < 78) begin
                queue_byte(CH_BSLASH);
                case ($urandom_range(0, 4))
                    0: begin
                        queue_byte($urandom_range(0, 1) ? 8'h78 : 8'h58);
                        if ($urandom_range(0, 5) != 0)
                            repeat ($urandom_range(1, 2))
                                queue_byte(hexset[$urandom_range(0, 21)]);
                    end
                    1: repeat ($urandom_range(1, 3))
                           queue_byte(8'($urandom_range(8'h30, 8'h37)));
                    2: queue_byte(escset[$urandom_range(0, 6)]);
                    default: queue_byte(8'($urandom_range(0, 255)));
                endcase
            end else if (kind < 84) begin
                queue_byte(CH_HASH);
            end else if (kind < 90) begin
                queue_byte(8'($urandom_range(0, 31)));
            end else begin
                queue_byte(8'($urandom_range(0, 255)));
            end
        end
        req_q.push_back(plain_row(8'($urandom_range(0, 255)), 1'b1));
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                tokenize_step(cur_req.data, cur_req.eol);
                if (cur_req.typed) begin
                    step_q.delete();
                    step_q.push_back(cur_req.want);
                end
                foreach (step_q[k]) want_q.push_back(step_q[k]);
                if (cur_req.eol) lines_done++;
            end
            if (o_out_valid && out_ready) begin
                got = {o_out_byte, o_byte_valid, o_word_end, o_line_end, o_error_code,
                       o_last_of_run};
                results_seen <= results_seen + 1;
                if (got.word_end) words_seen++;
                if (got.error_code != ERR_NONE) errors_seen++;
                if (want_q.size() == 0) begin
                    $display("%0t: result %0h with none expected", $time, got);
                    fail_cnt++;
                end else begin
                    want = want_q.pop_front();
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
                    check_field("word_end", 8'(want.word_end), 8'(got.word_end));
                    check_field("line_end", 8'(want.line_end), 8'(got.line_end));
                    check_field("error_code", 8'(want.error_code), 8'(got.error_code));
                    check_field("last_of_run", 8'(want.last_of_run),
                                8'(got.last_of_run));
                end
            end
        end
    end

    initial begin
        int  pause;
        bit  held;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // hold off once so the block fills and stalls its input
            if (!held && results_seen >= 100) begin
                held  = 1'b1;
                pause = 200;
            end else begin
                pause = calm ? 0 : $urandom_range(0, 5);
            end
            if (pause > 0) begin
                out_ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        t_request directed_tbl [26];
        int       pause;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        cur_req      = '0;
        calm         = 1'b0;
        fail_cnt     = 0;
        results_seen = 0;
        lines_done   = 0;
        words_seen   = 0;
        errors_seen  = 0;
        clear_parse();

        directed_tbl = '{
            typed_row(8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE),
            typed_row(CH_HASH, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE),
            plain_row(8'h00, 1'b1),
            plain_row(CH_SPACE, 1'b0),
            typed_row(8'hff, 1'b0, 8'hff, 1'b1, 1'b0, 1'b0, ERR_NONE),
            plain_row(CH_BSLASH, 1'b0),
            plain_row("x", 1'b0),
            plain_row("4", 1'b0),
            plain_row("1", 1'b0),
            plain_row(CH_BSLASH, 1'b0),
            plain_row("7", 1'b0),
            plain_row(CH_SPACE, 1'b0),
            typed_row(CH_HASH, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE),
            plain_row("A", 1'b1),
            plain_row(CH_DQUOTE, 1'b0),
            typed_row(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ERR_CONTROL),
            plain_row(8'h00, 1'b1),
            plain_row(CH_SQUOTE, 1'b0),
            plain_row(CH_BSLASH, 1'b0),
            typed_row(8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, ERR_UNCLOSED),
            plain_row(CH_BSLASH, 1'b0),
            plain_row("X", 1'b0),
            typed_row("g", 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ERR_ESCAPE),
            plain_row(8'h00, 1'b1),
            plain_row(CH_BSLASH, 1'b0),
            plain_row(8'hff, 1'b1)
        };
        foreach (directed_tbl[k]) req_q.push_back(directed_tbl[k]);
        while (req_q.size() < 676) queue_line();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (req_q[k]) begin
            if ($urandom_range(0, 39) == 0) calm <= ~calm;
            pause = calm ? 0 : $urandom_range(0, 5);
            if (pause > 0) begin
                in_valid <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            in_valid <= 1'b1;
            cur_req  <= req_q[k];
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
        end
        in_valid <= 1'b0;
        @(posedge i_clk);

        // drain, then watch for stray results
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d requests over %0d lines, %0d results checked.",
                 req_q.size(), lines_done, results_seen);
        $display("Saw %0d closed words and %0d error endings, %0d mismatches.",
                 words_seen, errors_seen, fail_cnt);
        if (fail_cnt == 0)
            $display("quoted_word_tokenizer_unit regression: pass");
        else
            $display("quoted_word_tokenizer_unit regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/qwt_pkg.sv
rtl/qwt_step.sv
rtl/qwt_outbuf.sv
rtl/quoted_word_tokenizer_unit.sv
rtl/qwt_checker.sv
tb/tb_quoted_word_tokenizer_unit.sv
